// ===== src/mrs_pkg.sv =====
// Shared types, constants and the CRC-16 step for the Modbus RTU slave responder.
package mrs_pkg;

	localparam int TableDepth  = 4096;
	localparam int AddrW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int MaxQuantity = 127;

	localparam logic [7:0] FnRdCoils    = 8'd1;
	localparam logic [7:0] FnRdDiscrete = 8'd2;
	localparam logic [7:0] FnRdHolding  = 8'd3;
	localparam logic [7:0] FnRdInput    = 8'd4;
	localparam logic [7:0] FnWrCoil     = 8'd5;
	localparam logic [7:0] FnWrHolding  = 8'd6;

	typedef enum logic [2:0] {
		KIND_RX      = 3'd0,
		KIND_TX      = 3'd1,
		KIND_RESTART = 3'd2,
		KIND_DISC    = 3'd3,
		KIND_INREG   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK   = 3'd0,
		STAT_CRC  = 3'd1,
		STAT_FUNC = 3'd2,
		STAT_ADDR = 3'd3,
		STAT_QTY  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_BITS,
		S_BIT_FIN,
		S_WORD_RD,
		S_WORD_DAT
	} state_t;

	typedef struct packed {
		logic        done;
		status_t     status;
		logic [7:0]  unit;
		logic [7:0]  fn;
		logic [15:0] start;
		logic [15:0] qty;
	} req_t;

	function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// ===== src/mrs_ram.sv =====
// Generic single-port RAM with registered read.
module mrs_ram #(
	parameter int Width = 16,
	parameter int Depth = 4096,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/mrs_req.sv =====
// Request byte collector with running CRC and limit checks.
module mrs_req (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_en,
	input  logic          restart,
	input  logic [7:0]    data_byte,
	output mrs_pkg::req_t req
);

	logic [2:0]  cnt_q;
	logic [15:0] crc_q;
	logic [7:0]  sh_q [7];
	logic [16:0] end_addr;
	logic [15:0] start;
	logic [15:0] qty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (restart) begin
			cnt_q <= '0;
		end else if (byte_en) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en) begin
			if (cnt_q < 3'd6) begin
				crc_q <= mrs_pkg::crc_update((cnt_q == 3'd0) ? 16'hFFFF : crc_q, data_byte);
			end
			sh_q[0] <= data_byte;
			for (int i = 1; i < 7; i++) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
	end

	assign start    = {sh_q[4], sh_q[3]};
	assign qty      = {sh_q[2], sh_q[1]};
	assign end_addr = {1'b0, start} + {1'b0, qty};

	always_comb begin
		req.done  = byte_en && (cnt_q == 3'd7);
		req.unit  = sh_q[6];
		req.fn    = sh_q[5];
		req.start = start;
		req.qty   = qty;
		if ({data_byte, sh_q[0]} != crc_q) begin
			req.status = mrs_pkg::STAT_CRC;
		end else if (sh_q[5] == mrs_pkg::FnRdCoils || sh_q[5] == mrs_pkg::FnRdDiscrete ||
				sh_q[5] == mrs_pkg::FnRdHolding || sh_q[5] == mrs_pkg::FnRdInput) begin
			if (qty > 16'(mrs_pkg::MaxQuantity)) begin
				req.status = mrs_pkg::STAT_QTY;
			end else if (end_addr > 17'(mrs_pkg::TableDepth)) begin
				req.status = mrs_pkg::STAT_ADDR;
			end else begin
				req.status = mrs_pkg::STAT_OK;
			end
		end else if (sh_q[5] == mrs_pkg::FnWrCoil || sh_q[5] == mrs_pkg::FnWrHolding) begin
			if ({1'b0, start} >= 17'(mrs_pkg::TableDepth)) begin
				req.status = mrs_pkg::STAT_ADDR;
			end else begin
				req.status = mrs_pkg::STAT_OK;
			end
		end else begin
			req.status = mrs_pkg::STAT_FUNC;
		end
	end

endmodule

// ===== src/modbus_rtu_slave_responder.sv =====
// Top level of the Modbus RTU slave responder: sequencer, tables and output register.
//
// Input channel (in_valid/in_stall): one request per cycle unless stalled; kinds:
// received byte, transmit slot, frame restart, local discrete or input-register write.
// Output channel (out_valid/out_stall) carries response bytes and error status items.
// Eight received bytes form a Modbus request; a good read or write starts a
// reply, a bad one gives one registered status item with last_byte set.
// Each transmit slot yields one response byte. Header, echo, count and CRC bytes
// are emitted straight from S_IDLE; a register data byte needs one table read
// (S_WORD_RD, S_WORD_DAT); a coil or discrete data byte needs eight single-bit
// table reads, one per cycle on the single table port (S_BITS), plus collect and
// emit (S_BIT_FIN). One request is worked on at a time; in_stall
// is high while a request is in progress or a result waits in the output register.
// After reset the four 4096-entry tables are cleared in one pass with in_stall
// high. When the receiver stalls, the output register holds
// its result and no new request is taken.
module modbus_rtu_slave_responder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic [15:0] local_addr,
	input  logic [15:0] local_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        last_byte,
	output logic [2:0]  status
);

	localparam int AW = mrs_pkg::AddrW;

	mrs_pkg::state_t state_q, state_d;
	mrs_pkg::req_t   req;

	logic [AW-1:0] clr_cnt_q;
	logic          pend_q;
	logic [7:0]    fn_q;
	logic [7:0]    unit_q;
	logic [15:0]   start_q;
	logic [15:0]   qty_q;
	logic [8:0]    pos_q;
	logic [15:0]   crc_q;
	logic [3:0]    bit_cnt_q;
	logic [7:0]    acc_q;
	logic [16:0]   base_q;
	logic [10:0]   off_q;
	logic          lo_sel_q;
	logic          rd_vld_s1;
	logic          rd_en_s1;
	logic [2:0]    rd_idx_s1;
	logic          out_valid_q;
	logic [7:0]    tx_byte_q;
	logic          last_q;
	logic [2:0]    status_q;

	logic          acc;
	logic          is_rx, is_tx, is_restart, is_disc, is_inreg;
	logic          is_bit, is_echo;
	logic [8:0]    dcount;
	logic [9:0]    len, p10, k;
	logic          body, last_now, needs_mem;
	logic [7:0]    direct_byte;
	logic          emit;
	logic [7:0]    emit_byte;
	logic          start_bits, start_word;
	logic          clearing;
	logic          local_ok;
	logic          req_ok;
	logic [16:0]   bit_addr;
	logic [10:0]   bit_n;
	logic          bit_en;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] coil_addr, disc_addr, hold_addr, inreg_addr;
	logic          coil_we, disc_we, hold_we, inreg_we;
	logic          coil_wd, disc_wd;
	logic [15:0]   hold_wd, inreg_wd;
	logic          coil_rd, disc_rd;
	logic [15:0]   hold_rd, inreg_rd, word;

	assign acc        = in_valid && !in_stall;
	assign is_rx      = acc && (kind == mrs_pkg::KIND_RX);
	assign is_tx      = acc && (kind == mrs_pkg::KIND_TX);
	assign is_restart = acc && (kind == mrs_pkg::KIND_RESTART);
	assign is_disc    = acc && (kind == mrs_pkg::KIND_DISC);
	assign is_inreg   = acc && (kind == mrs_pkg::KIND_INREG);
	assign clearing   = (state_q == mrs_pkg::S_CLEAR);
	assign local_ok   = ({1'b0, local_addr} < 17'(mrs_pkg::TableDepth));

	mrs_req u_req (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (is_rx && !pend_q),
		.restart   (is_restart),
		.data_byte (data_byte),
		.req       (req)
	);

	assign req_ok = req.done && (req.status == mrs_pkg::STAT_OK);

	assign is_bit  = (fn_q == mrs_pkg::FnRdCoils) || (fn_q == mrs_pkg::FnRdDiscrete);
	assign is_echo = (fn_q == mrs_pkg::FnWrCoil) || (fn_q == mrs_pkg::FnWrHolding);
	assign dcount  = is_bit ? ((qty_q[8:0] + 9'd7) >> 3) : {qty_q[7:0], 1'b0};
	assign len     = is_echo ? 10'd8 : (10'd5 + {1'b0, dcount});
	assign p10     = {1'b0, pos_q};
	assign k       = p10 - 10'd3;
	assign body    = (p10 + 10'd2) < len;
	assign last_now  = (p10 + 10'd1) >= len;
	assign needs_mem = body && !is_echo && (pos_q >= 9'd3);

	always_comb begin
		if (!body) begin
			direct_byte = ((p10 + 10'd2) == len) ? crc_q[7:0] : crc_q[15:8];
		end else if (pos_q == 9'd0) begin
			direct_byte = unit_q;
		end else if (pos_q == 9'd1) begin
			direct_byte = fn_q;
		end else if (is_echo) begin
			case (pos_q)
				9'd2:    direct_byte = start_q[15:8];
				9'd3:    direct_byte = start_q[7:0];
				9'd4:    direct_byte = qty_q[15:8];
				default: direct_byte = qty_q[7:0];
			endcase
		end else begin
			direct_byte = dcount[7:0];
		end
	end

	assign bit_addr = base_q + 17'(bit_cnt_q);
	assign bit_n    = off_q + 11'(bit_cnt_q);
	assign bit_en   = ({5'b0, bit_n} < qty_q);
	assign word     = (fn_q == mrs_pkg::FnRdHolding) ? hold_rd : inreg_rd;
	assign rd_addr  = (state_q == mrs_pkg::S_BITS) ? bit_addr[AW-1:0] : base_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrs_pkg::S_CLEAR: begin
				if (clr_cnt_q == AW'(mrs_pkg::TableDepth - 1)) begin
					state_d = mrs_pkg::S_IDLE;
				end
			end
			mrs_pkg::S_IDLE: begin
				if (start_bits) begin
					state_d = mrs_pkg::S_BITS;
				end else if (start_word) begin
					state_d = mrs_pkg::S_WORD_RD;
				end
			end
			mrs_pkg::S_BITS: begin
				if (bit_cnt_q[3]) begin
					state_d = mrs_pkg::S_BIT_FIN;
				end
			end
			mrs_pkg::S_BIT_FIN:  state_d = mrs_pkg::S_IDLE;
			mrs_pkg::S_WORD_RD:  state_d = mrs_pkg::S_WORD_DAT;
			mrs_pkg::S_WORD_DAT: state_d = mrs_pkg::S_IDLE;
			default:             state_d = mrs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		start_bits = 1'b0;
		start_word = 1'b0;
		emit       = 1'b0;
		emit_byte  = direct_byte;
		unique case (state_q)
			mrs_pkg::S_IDLE: begin
				if (is_tx && pend_q) begin
					if (needs_mem) begin
						start_bits = is_bit;
						start_word = !is_bit;
					end else begin
						emit = 1'b1;
					end
				end
			end
			mrs_pkg::S_BIT_FIN: begin
				emit      = 1'b1;
				emit_byte = acc_q;
			end
			mrs_pkg::S_WORD_DAT: begin
				emit      = 1'b1;
				emit_byte = lo_sel_q ? word[7:0] : word[15:8];
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrs_pkg::S_CLEAR;
			clr_cnt_q   <= '0;
			pend_q      <= 1'b0;
			pos_q       <= '0;
			crc_q       <= 16'hFFFF;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == mrs_pkg::S_BITS) && !bit_cnt_q[3];
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (req.done) begin
				if (req_ok) begin
					pend_q <= 1'b1;
					pos_q  <= '0;
					crc_q  <= 16'hFFFF;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				if (body) begin
					crc_q <= mrs_pkg::crc_update(crc_q, emit_byte);
				end
				if (last_now) begin
					pend_q <= 1'b0;
					pos_q  <= '0;
				end else begin
					pos_q <= pos_q + 9'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ok) begin
			unit_q  <= req.unit;
			fn_q    <= req.fn;
			start_q <= req.start;
			qty_q   <= req.qty;
		end
		if (req.done && !req_ok) begin
			tx_byte_q <= 8'd0;
			last_q    <= 1'b1;
			status_q  <= req.status;
		end
		if (emit) begin
			tx_byte_q <= emit_byte;
			last_q    <= last_now;
			status_q  <= mrs_pkg::STAT_OK;
		end
		if (start_bits) begin
			base_q    <= {1'b0, start_q} + {7'd0, k[6:0], 3'b000};
			off_q     <= {1'b0, k[6:0], 3'b000};
			bit_cnt_q <= '0;
			acc_q     <= '0;
		end
		if (start_word) begin
			base_q   <= {1'b0, start_q} + {8'd0, k[9:1]};
			lo_sel_q <= k[0];
		end
		if (state_q == mrs_pkg::S_BITS && !bit_cnt_q[3]) begin
			bit_cnt_q <= bit_cnt_q + 4'd1;
			rd_idx_s1 <= bit_cnt_q[2:0];
			rd_en_s1  <= bit_en;
		end
		if (rd_vld_s1) begin
			acc_q[rd_idx_s1] <= rd_en_s1 &&
				((fn_q == mrs_pkg::FnRdCoils) ? coil_rd : disc_rd);
		end
	end

	always_comb begin
		coil_we    = clearing || (req_ok && req.fn == mrs_pkg::FnWrCoil);
		coil_wd    = !clearing && (req.qty != 16'd0);
		hold_we    = clearing || (req_ok && req.fn == mrs_pkg::FnWrHolding);
		hold_wd    = clearing ? 16'd0 : req.qty;
		disc_we    = clearing || (is_disc && local_ok);
		disc_wd    = !clearing && (local_value != 16'd0);
		inreg_we   = clearing || (is_inreg && local_ok);
		inreg_wd   = clearing ? 16'd0 : local_value;
		coil_addr  = rd_addr;
		hold_addr  = rd_addr;
		disc_addr  = rd_addr;
		inreg_addr = rd_addr;
		if (clearing) begin
			coil_addr  = clr_cnt_q;
			hold_addr  = clr_cnt_q;
			disc_addr  = clr_cnt_q;
			inreg_addr = clr_cnt_q;
		end else if (state_q == mrs_pkg::S_IDLE) begin
			coil_addr  = req.start[AW-1:0];
			hold_addr  = req.start[AW-1:0];
			disc_addr  = local_addr[AW-1:0];
			inreg_addr = local_addr[AW-1:0];
		end
	end

	mrs_ram #(.Width(1), .Depth(mrs_pkg::TableDepth)) u_coil (
		.clk (clk), .we (coil_we), .addr (coil_addr), .wdata (coil_wd), .rdata (coil_rd)
	);

	mrs_ram #(.Width(1), .Depth(mrs_pkg::TableDepth)) u_disc (
		.clk (clk), .we (disc_we), .addr (disc_addr), .wdata (disc_wd), .rdata (disc_rd)
	);

	mrs_ram #(.Width(16), .Depth(mrs_pkg::TableDepth)) u_hold (
		.clk (clk), .we (hold_we), .addr (hold_addr), .wdata (hold_wd), .rdata (hold_rd)
	);

	mrs_ram #(.Width(16), .Depth(mrs_pkg::TableDepth)) u_inreg (
		.clk (clk), .we (inreg_we), .addr (inreg_addr), .wdata (inreg_wd), .rdata (inreg_rd)
	);

	assign in_stall  = (state_q != mrs_pkg::S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign last_byte = last_q;
	assign status    = status_q;

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != mrs_pkg::STAT_OK) |-> last_q)
		else $error("error item without last_byte");

	a_read_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrs_pkg::S_BITS || state_q == mrs_pkg::S_WORD_RD ||
		 state_q == mrs_pkg::S_WORD_DAT) |-> (pend_q && !out_valid_q))
		else $error("table read without pending reply or with output occupied");

	a_clear_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!out_valid_q && !pend_q))
		else $error("activity during clearing pass");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_now) |=> !pend_q)
		else $error("reply still pending after last byte");

endmodule
